FILE: sv/assert_macros.svh
// Assertion macros shared by the cache modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: sv/rcc_pkg.sv
// Package for the reference-counted cache: operation codes, status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package rcc_pkg;
    localparam int FUNC_W = 3;
    localparam int KEY_W = 64;
    localparam int TIME_W = 32;
    localparam int TMO_W = 31;
    localparam int ST_W = 2;
    localparam logic [TIME_W-1:0] GRACE_MS = 32'd1000;
    localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT = 31'd5000;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INCR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CONTAINS = 3'd4;
    localparam logic [FUNC_W-1:0] FN_TICK = 3'd5;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_NULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_SWEEP,
        S_RESULT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input transfer
        logic scan_init; // start a scan at the newest (search) or slot 0 (sweep)
        logic search;    // examine one slot, newest to oldest
        logic sweep;     // examine and compact one slot, oldest first
        logic update;    // apply the operation's write
        logic finish;    // latch the result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic search_done;
        logic sweep_done;
    } t_stat;
endpackage
`default_nettype wire

FILE: sv/rcc_if.sv
// Valid/ready channels carrying struct-free sets of fields: rcc_req_if for
// the request channel and rcc_rsp_if for the result channel.
`default_nettype none
interface rcc_req_if #(parameter int HANDLE_BITS = 16);
    logic valid;
    logic ready;
    logic [2:0] func;
    logic [63:0] key;
    logic [HANDLE_BITS-1:0] handle;
    logic [31:0] now;
    modport source (output valid, func, key, handle, now, input ready);
    modport sink (input valid, func, key, handle, now, output ready);
endinterface

interface rcc_rsp_if #(parameter int HANDLE_BITS = 16);
    logic valid;
    logic ready;
    logic [1:0] status;
    logic hit;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [4:0] evicted_count;
    logic [4:0] pending_count;
    logic timer_active;
    modport source (output valid, status, hit, handle_out, evicted_count,
                    pending_count, timer_active, input ready);
    modport sink (input valid, status, hit, handle_out, evicted_count,
                  pending_count, timer_active, output ready);
endinterface
`default_nettype wire

FILE: sv/rcc_ctrl.sv
// Controller state machine for the reference-counted cache.
// Depends on rcc_pkg; drives the datapath through t_cmd.
`default_nettype none
`include "assert_macros.svh"
module rcc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [2:0]    i_func,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rcc_pkg::t_stat i_stat,
    output rcc_pkg::t_cmd      o_cmd
);
    import rcc_pkg::*;

    t_state r_state, n_state;
    logic [FUNC_W-1:0] r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func <= i_func;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    if (i_func == FN_TICK) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (i_stat.search_done) begin
                    n_state = S_UPDATE;
                end else begin
                    o_cmd.search = 1'b1;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                o_cmd.finish = 1'b1;
                n_state = S_RESULT;
            end
            S_SWEEP: begin
                if (i_stat.sweep_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.sweep = 1'b1;
                end
            end
            S_RESULT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready |-> r_state == S_IDLE)
    `ASSERT_IMPL(a_accept_leaves, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> r_state != S_IDLE)
    `ASSERT_IMPL(a_sweep_tick, i_clk, i_rst_n,
        (r_state == S_SWEEP) |-> r_func == FN_TICK)
endmodule
`default_nettype wire

FILE: sv/rcc_dp.sv
// Datapath for the reference-counted cache: slot memory in flip-flops,
// scan pointers, the compaction sweep and the result register. Uses rcc_pkg.
`default_nettype none
`include "assert_macros.svh"
module rcc_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int HANDLE_BITS = 16,
    parameter int REF_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire rcc_pkg::t_cmd          i_cmd,
    output rcc_pkg::t_stat              o_stat,
    input  wire logic [2:0]             i_func,
    input  wire logic [63:0]            i_key,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    input  wire logic [31:0]            i_now,
    input  wire logic                   i_cfg_we,
    input  wire logic [30:0]            i_cfg_data,
    output logic [1:0]                  o_status,
    output logic                        o_hit,
    output logic [HANDLE_BITS-1:0]      o_handle_out,
    output logic [4:0]                  o_evicted_count,
    output logic [4:0]                  o_pending_count,
    output logic                        o_timer_active
);
    import rcc_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    logic [KEY_W-1:0]       r_key_mem [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0] r_hdl_mem [TABLE_DEPTH];
    logic [REF_BITS-1:0]    r_ref_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]      r_tim_mem [TABLE_DEPTH];

    logic [CW-1:0] r_count;
    logic          r_armed;
    logic [TMO_W-1:0] r_timeout;

    logic [FUNC_W-1:0]      r_func;
    logic [KEY_W-1:0]       r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [TIME_W-1:0]      r_now;

    // Search: r_ptr counts remaining slots; slot index is r_ptr - 1.
    // Sweep: r_ptr is the read index, r_wr the write index.
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_wr;
    logic          r_found;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_evicted;
    logic [CW-1:0] r_pending;

    logic [IW-1:0] s_rd;
    logic [IW-1:0] s_wi;
    logic          s_match;
    logic          s_zero;
    logic          s_expired;
    logic [TIME_W-1:0] s_t;

    assign o_stat.search_done = r_found || (r_ptr == '0);
    assign o_stat.sweep_done = (r_ptr == r_count);

    always_comb begin
        logic [CW-1:0] p;
        p = r_ptr - CW'(1);
        s_rd = (i_cmd.sweep) ? r_ptr[IW-1:0] : p[IW-1:0];
    end
    assign s_wi = r_wr[IW-1:0];

    assign s_match = (r_func == FN_LOOKUP) ? (r_key_mem[s_rd] == r_key)
                                           : (r_hdl_mem[s_rd] == r_handle);
    assign s_t = r_tim_mem[s_rd];
    assign s_zero = (r_ref_mem[s_rd] == '0);
    assign s_expired = r_armed &&
        ((r_now > (s_t + {1'b0, r_timeout})) || (r_now < (s_t - GRACE_MS)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key <= i_key;
            r_handle <= i_handle;
            r_now <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_wr <= '0;
            r_found <= 1'b0;
            r_evicted <= '0;
            r_pending <= '0;
        end else if (i_cmd.scan_init) begin
            r_ptr <= (i_func == FN_TICK) ? '0 : r_count;
            r_wr <= '0;
            r_found <= 1'b0;
            r_evicted <= '0;
            r_pending <= '0;
        end else if (i_cmd.search) begin
            if (s_match) begin
                r_found <= 1'b1;
                r_idx <= s_rd;
            end else begin
                r_ptr <= r_ptr - CW'(1);
            end
        end else if (i_cmd.sweep) begin
            r_ptr <= r_ptr + CW'(1);
            if (s_zero && s_expired) begin
                r_evicted <= r_evicted + CW'(1);
            end else begin
                r_wr <= r_wr + CW'(1);
                if (s_zero) begin
                    r_pending <= r_pending + CW'(1);
                end
            end
        end
    end

    // Slot memory and table state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && !(s_zero && s_expired)) begin
            r_key_mem[s_wi] <= r_key_mem[s_rd];
            r_hdl_mem[s_wi] <= r_hdl_mem[s_rd];
            r_ref_mem[s_wi] <= r_ref_mem[s_rd];
            r_tim_mem[s_wi] <= s_t;
        end else if (i_cmd.update) begin
            case (r_func)
                FN_INSERT: begin
                    if (r_handle != '0 && r_count < CW'(TABLE_DEPTH)) begin
                        r_key_mem[r_count[IW-1:0]] <= r_key;
                        r_hdl_mem[r_count[IW-1:0]] <= r_handle;
                        r_ref_mem[r_count[IW-1:0]] <= REF_BITS'(1);
                        r_tim_mem[r_count[IW-1:0]] <= '0;
                    end
                end
                FN_LOOKUP, FN_INCR: begin
                    if (r_found && r_ref_mem[r_idx] != REF_MAX) begin
                        r_ref_mem[r_idx] <= r_ref_mem[r_idx] + REF_BITS'(1);
                    end
                end
                FN_RELEASE: begin
                    if (r_handle != '0 && r_found && r_ref_mem[r_idx] != '0) begin
                        r_ref_mem[r_idx] <= r_ref_mem[r_idx] - REF_BITS'(1);
                        if (r_ref_mem[r_idx] == REF_BITS'(1)) begin
                            r_tim_mem[r_idx] <= r_now;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_armed <= 1'b0;
        end else if (i_cmd.finish && r_func == FN_TICK) begin
            r_count <= r_wr;
            if (r_pending == '0) begin
                r_armed <= 1'b0;
            end
        end else if (i_cmd.update) begin
            if (r_func == FN_INSERT && r_handle != '0 && r_count < CW'(TABLE_DEPTH)) begin
                r_count <= r_count + CW'(1);
            end
            if (r_func == FN_RELEASE && r_handle != '0 && r_found) begin
                r_armed <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status <= ST_OK;
            o_hit <= 1'b0;
            o_handle_out <= '0;
            o_evicted_count <= '0;
            o_pending_count <= '0;
            o_timer_active <= r_armed;
            case (r_func)
                FN_LOOKUP: begin
                    if (r_found) begin
                        o_hit <= 1'b1;
                        o_handle_out <= r_hdl_mem[r_idx];
                    end else begin
                        o_status <= ST_NOT_FOUND;
                    end
                end
                FN_INSERT: begin
                    if (r_handle == '0) begin
                        o_status <= ST_NULL;
                    end else if (r_count >= CW'(TABLE_DEPTH)) begin
                        o_status <= ST_FULL;
                    end
                end
                FN_RELEASE: begin
                    if (r_handle == '0) begin
                        o_status <= ST_NULL;
                    end else if (!r_found) begin
                        o_status <= ST_NOT_FOUND;
                    end else begin
                        o_timer_active <= 1'b1;
                    end
                end
                FN_INCR: begin
                    if (!r_found) o_status <= ST_NOT_FOUND;
                end
                FN_CONTAINS: begin
                    if (r_found) o_hit <= 1'b1;
                    else o_status <= ST_NOT_FOUND;
                end
                FN_TICK: begin
                    o_evicted_count <= 5'(r_evicted);
                    o_pending_count <= 5'(r_pending);
                    o_timer_active <= r_armed && (r_pending != '0);
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH))
    `ASSERT_IMPL(a_wr_behind, i_clk, i_rst_n, i_cmd.sweep |-> r_wr <= r_ptr)
    `ASSERT_IMPL(a_tally, i_clk, i_rst_n,
        i_cmd.sweep |-> (r_wr + r_evicted) == r_ptr)
endmodule
`default_nettype wire

FILE: sv/refcounted_cache_with_timed_eviction_unit.sv
// Top level of the reference-counted cache with timed eviction.
// Depends on rcc_pkg, rcc_if, rcc_ctrl and rcc_dp.
// One operation at a time. Every operation except a tick, inserts and unused
// codes included, scans the table newest to oldest, one slot per cycle, and
// stops at the first match. The controller then sees the scan end in S_SEARCH
// and writes in S_UPDATE, which also latches the result; the result is valid
// in S_RESULT. A tick sweeps every stored slot oldest first and compacts in
// place; its result is latched when the sweep ends and is valid in S_RESULT.
// After the result transfer the controller returns to S_IDLE, where it
// accepts the next operation. The slot scan sets the rate when the output
// does not stall. timeout_ms is to be written through i_cfg_we/i_cfg_data
// only while idle; the block itself does not enforce this. No clearing pass
// is needed.
`default_nettype none
module refcounted_cache_with_timed_eviction_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int HANDLE_BITS = 16,
    parameter int REF_BITS = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    rcc_req_if.sink         i_req,
    rcc_rsp_if.source       o_rsp,
    input wire logic        i_cfg_we,
    input wire logic [30:0] i_cfg_data
);
    import rcc_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    rcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_func     (i_req.func),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    rcc_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .HANDLE_BITS(HANDLE_BITS),
        .REF_BITS   (REF_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_stat         (s_stat),
        .i_func         (i_req.func),
        .i_key          (i_req.key),
        .i_handle       (i_req.handle),
        .i_now          (i_req.now),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_status       (o_rsp.status),
        .o_hit          (o_rsp.hit),
        .o_handle_out   (o_rsp.handle_out),
        .o_evicted_count(o_rsp.evicted_count),
        .o_pending_count(o_rsp.pending_count),
        .o_timer_active (o_rsp.timer_active)
    );
endmodule
`default_nettype wire
